### design/ipks_pkg.sv
// package for the indexed page key search block
// holds sizing constants, command and status codes, fsm state and result types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ipks_pkg;

    localparam int PAGE_ITEMS = 8;
    localparam int MAX_PAGES  = 128;
    localparam int CAPACITY   = PAGE_ITEMS * MAX_PAGES;

    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 10;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    // record counter holds the capacity itself, record address does not
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int PG_AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCNT_W = $clog2(MAX_PAGES + 1);
    localparam int ITEM_W = $clog2(PAGE_ITEMS + 1);
    localparam int SIDX_W = ITEM_W + 1;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_APPEND = t_cmd'(0);
    localparam t_cmd CMD_SEARCH = t_cmd'(1);
    localparam t_cmd CMD_CLEAR  = t_cmd'(2);

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_CLEARED   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_BS_RD,
        S_BS_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [DATA_W-1:0]   data;
        logic [POS_W-1:0]    pos;
    } t_result;

endpackage

`default_nettype wire

### design/ipks_ram.sv
// generic simple dual port ram, one write port and one read port
// read data is registered; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ipks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/indexed_page_key_search.sv
// indexed page key search: record store, page index and search sequencer
// depends on ipks_pkg and ipks_ram
//
// usage:
//   input channel  i_in_valid / o_in_ready carries i_cmd, i_key, i_payload
//   output channel o_out_valid / i_out_ready carries o_status, o_found_data, o_position
//   every input transaction gives exactly one output transaction, in order
// sequence per command, from accept to o_out_valid:
//   append, clear, unused code: S_IDLE, S_DONE, then the output register
//   search: S_IDLE, S_SCAN over the index, then S_BS_RD and S_BS_CHK per probe,
//           then S_DONE and the output register
//   the index scan reads one page key per cycle from the index memory; the
//   binary search takes a read state and a compare state of the record memory per probe
// throughput: one command at a time; o_in_ready is high only while the sequencer idles,
//   and it idles again as soon as the result sits in the output register
// reset: record count is zero, store contents stay undefined (no clearing pass);
//   a search only reads entries written since the last clear
// stall: a held result waits in the output register; the next command is
//   accepted meanwhile and its result waits in the sequencer until the slot frees
`timescale 1ns / 1ps
`default_nettype none

module indexed_page_key_search (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ipks_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [ipks_pkg::KEY_W-1:0]    i_key,
    input  wire logic [ipks_pkg::DATA_W-1:0]   i_payload,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ipks_pkg::STATUS_W-1:0]      o_status,
    output logic [ipks_pkg::DATA_W-1:0]        o_found_data,
    output logic [ipks_pkg::POS_W-1:0]         o_position
);

    import ipks_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PCNT_W-1:0]   r_pages, n_pages;
    logic [ITEM_W-1:0]   r_fill, n_fill;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [PCNT_W-1:0]   r_p, n_p;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic signed [SIDX_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [ITEM_W-1:0]   r_mid, n_mid;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                      rec_we;
    logic [ADDR_W-1:0]         rec_raddr;
    logic [KEY_W+DATA_W-1:0]   rec_rdata;
    logic [KEY_W-1:0]          rec_key;
    logic [DATA_W-1:0]         rec_data;
    logic                      idx_we;
    logic [PG_AW-1:0]          idx_raddr;
    logic [KEY_W-1:0]          idx_rdata;

    logic                      in_acc;
    logic                      out_load;
    logic                      page_ok;
    logic                      last_page;
    logic [ITEM_W-1:0]         page_items;
    logic signed [SIDX_W-1:0]  mid;
    logic signed [SIDX_W-1:0]  bs_lo, bs_hi;
    logic                      key_eq, key_lt;
    logic [ADDR_W-1:0]         rec_idx;
    logic [PCNT_W-1:0]         p_next;

    // stores; writes happen only at accept, read data is used only while searching
    ipks_ram #(
        .WIDTH (KEY_W + DATA_W),
        .DEPTH (CAPACITY)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_key, i_payload}),
        .i_raddr (rec_raddr),
        .o_rdata (rec_rdata)
    );

    ipks_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_PAGES)
    ) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (r_pages[PG_AW-1:0]),
        .i_wdata (i_key),
        .i_raddr (idx_raddr),
        .o_rdata (idx_rdata)
    );

    assign rec_key  = rec_rdata[KEY_W+DATA_W-1:DATA_W];
    assign rec_data = rec_rdata[DATA_W-1:0];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // index scan: data in S_SCAN is the first key of page r_p
    assign p_next    = r_p + PCNT_W'(1);
    assign page_ok   = (r_p < r_pages) && ($signed(idx_rdata) <= $signed(r_key));
    assign idx_raddr = (r_state == S_SCAN) ? p_next[PG_AW-1:0] : '0;

    // chosen page is r_p - 1; the last page may be short
    assign last_page  = (r_p == r_pages);
    assign page_items = (last_page && (r_fill != '0)) ? r_fill : ITEM_W'(PAGE_ITEMS);

    // binary search probe
    assign mid       = r_lo + ((r_hi - r_lo) >>> 1);
    assign rec_raddr = r_base + ADDR_W'(mid);
    assign rec_idx   = r_base + ADDR_W'(r_mid);
    assign key_eq    = (rec_key == r_key);
    assign key_lt    = ($signed(rec_key) < $signed(r_key));
    assign bs_lo     = key_lt ? ($signed({1'b0, r_mid}) + SIDX_W'(1)) : r_lo;
    assign bs_hi     = key_lt ? r_hi : ($signed({1'b0, r_mid}) - SIDX_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_cmd == CMD_SEARCH) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (!page_ok) begin
                    n_state = (r_p == '0) ? S_DONE : S_BS_RD;
                end
            end
            S_BS_RD: begin
                n_state = S_BS_CHK;
            end
            S_BS_CHK: begin
                if (key_eq || (bs_lo > bs_hi)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_BS_RD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_count     = r_count;
        n_pages     = r_pages;
        n_fill      = r_fill;
        n_key       = r_key;
        n_p         = r_p;
        n_base      = r_base;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        rec_we      = 1'b0;
        idx_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key = i_key;
                    n_p   = '0;
                    n_res = '{status: ST_NOT_FOUND, data: '0, pos: '0};
                    unique case (i_cmd)
                        CMD_APPEND: begin
                            if (r_count < CNT_W'(CAPACITY)) begin
                                rec_we       = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                                n_res.status = ST_APPENDED;
                                // first record of a page also goes into the index
                                if (r_fill == '0) begin
                                    idx_we  = 1'b1;
                                    n_pages = r_pages + PCNT_W'(1);
                                end
                                n_fill = (r_fill == ITEM_W'(PAGE_ITEMS - 1)) ?
                                         '0 : r_fill + ITEM_W'(1);
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count      = '0;
                            n_pages      = '0;
                            n_fill       = '0;
                            n_res.status = ST_CLEARED;
                        end
                        default: n_res.status = ST_NOT_FOUND;
                    endcase
                end
            end
            S_SCAN: begin
                if (page_ok) begin
                    n_p = p_next;
                end else if (r_p != '0) begin
                    n_base = ADDR_W'((r_p - PCNT_W'(1)) * PAGE_ITEMS);
                    n_lo   = '0;
                    n_hi   = $signed({1'b0, page_items}) - SIDX_W'(1);
                end
            end
            S_BS_RD: begin
                n_mid = ITEM_W'(mid);
            end
            S_BS_CHK: begin
                if (key_eq) begin
                    n_res = '{status: ST_FOUND, data: rec_data, pos: POS_W'(rec_idx)};
                end else begin
                    n_lo = bs_lo;
                    n_hi = bs_hi;
                end
            end
            S_DONE: ;
            default: ;
        endcase

        if (out_load) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pages     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pages     <= n_pages;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_p    <= n_p;
        r_base <= n_base;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_found_data = r_out.data;
    assign o_position   = r_out.pos;

    // count, page count and fill level describe the same store
    a_count_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) ? (32'(r_count) == 32'(r_pages) * PAGE_ITEMS)
                       : (32'(r_count) == (32'(r_pages) - 1) * PAGE_ITEMS + 32'(r_fill)))
        else $error("record count disagrees with page count and fill");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_we |-> (r_count < CNT_W'(CAPACITY)))
        else $error("record write past capacity");

    a_probe_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BS_RD) |-> ((r_lo <= r_hi) && (r_lo >= 0)
                                  && (r_hi < $signed(SIDX_W'(PAGE_ITEMS)))))
        else $error("binary search probe outside the page");

    a_probe_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BS_RD) |=> (CNT_W'(rec_idx) < r_count))
        else $error("probe of a record beyond the fill level");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result left the sequencer while the output slot was busy");

endmodule

`default_nettype wire

### sim/indexed_page_key_search_checker.sv
// checker for indexed_page_key_search: keeps its own copy of the record store and
// page index, predicts one response per command and compares it with the output channel
// depends on ipks_pkg
`timescale 1ns / 1ps

module indexed_page_key_search_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [ipks_pkg::CMD_W-1:0]       i_cmd,
    input  logic [ipks_pkg::KEY_W-1:0]       i_key,
    input  logic [ipks_pkg::DATA_W-1:0]      i_payload,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [ipks_pkg::STATUS_W-1:0]    i_status,
    input  logic [ipks_pkg::DATA_W-1:0]      i_found_data,
    input  logic [ipks_pkg::POS_W-1:0]       i_position,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_found_count,
    output int                               o_full_count
);
    import ipks_pkg::*;

    logic signed [KEY_W-1:0] rec_key [CAPACITY];
    logic [DATA_W-1:0]       rec_data [CAPACITY];
    logic signed [KEY_W-1:0] page_key [MAX_PAGES];
    int                      rec_count;
    t_result                 pending_responses [$];

    function automatic t_result store_response(t_cmd cmd, logic signed [KEY_W-1:0] key,
                                               logic [DATA_W-1:0] payload);
        t_result r;
        int      pages;
        int      pg;
        int      n_items;
        int      base;
        int      lo;
        int      hi;
        int      mid;
        r.status = ST_NOT_FOUND;
        r.data   = '0;
        r.pos    = '0;
        case (cmd)
            CMD_APPEND: begin
                if (rec_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    rec_key[rec_count]  = key;
                    rec_data[rec_count] = payload;
                    if (rec_count % PAGE_ITEMS == 0)
                        page_key[rec_count / PAGE_ITEMS] = key;
                    rec_count++;
                    r.status = ST_APPENDED;
                end
            end
            CMD_CLEAR: begin
                rec_count = 0;
                r.status  = ST_CLEARED;
            end
            CMD_SEARCH: begin
                pages = (rec_count + PAGE_ITEMS - 1) / PAGE_ITEMS;
                pg    = 0;
                // walk the index while the page's first key does not exceed the key
                while (pg < pages && page_key[pg] <= key)
                    pg++;
                if (pg > 0) begin
                    n_items = (pg < pages) ? PAGE_ITEMS : rec_count - (pages - 1) * PAGE_ITEMS;
                    base    = (pg - 1) * PAGE_ITEMS;
                    lo      = 0;
                    hi      = n_items - 1;
                    while (lo <= hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (rec_key[base + mid] == key) begin
                            r.status = ST_FOUND;
                            r.data   = rec_data[base + mid];
                            r.pos    = POS_W'(base + mid);
                            break;
                        end
                        if (rec_key[base + mid] < key)
                            lo = mid + 1;
                        else
                            hi = mid - 1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            rec_count = 0;
            pending_responses.delete();
        end else begin
            // the response leaving now always belongs to an older transaction
            if (i_out_valid && i_out_ready) begin
                if (pending_responses.size() == 0) begin
                    $error("status: expected no response, got %0d", i_status);
                    o_fail_count++;
                end else begin
                    want = pending_responses.pop_front();
                    if (want.status == ST_FOUND)
                        o_found_count++;
                    if (want.status == ST_FULL)
                        o_full_count++;
                    if (i_status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_found_data != want.data) begin
                        $error("found_data: expected %h, got %h", want.data, i_found_data);
                        o_fail_count++;
                    end
                    if (i_position != want.pos) begin
                        $error("position: expected %0d, got %0d", want.pos, i_position);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pending_responses.push_back(store_response(t_cmd'(i_cmd), i_key, i_payload));
        end
        o_pending = pending_responses.size();
    end

endmodule

### sim/indexed_page_key_search_tb.sv
// testbench top for indexed_page_key_search: clock, reset, command stimulus and verdict
// depends on ipks_pkg, indexed_page_key_search and indexed_page_key_search_checker
`timescale 1ns / 1ps

module indexed_page_key_search_tb;
    import ipks_pkg::*;

    localparam int   LIMIT        = 3_000_000;
    localparam int   RANDOM_ITEMS = 80;
    localparam t_cmd CMD_UNUSED   = t_cmd'(3);

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                out_ready = 1'b0;
    t_cmd                cmd       = CMD_APPEND;
    logic [KEY_W-1:0]    key       = '0;
    logic [DATA_W-1:0]   payload   = '0;
    logic                in_ready;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   found_data;
    logic [POS_W-1:0]    position;

    int fail_count;
    int pending;
    int found_count;
    int full_count;
    int cycle_count;
    int sent;
    int n_append;
    int n_search;
    int n_clear;
    bit steady;

    // keys the store should hold since the last clear, used to aim searches
    logic [KEY_W-1:0] file_keys [$];

    always #5 clk = ~clk;

    indexed_page_key_search i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_cmd        (cmd),
        .i_key        (key),
        .i_payload    (payload),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_found_data (found_data),
        .o_position   (position)
    );

    indexed_page_key_search_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_cmd         (cmd),
        .i_key         (key),
        .i_payload     (payload),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_found_data  (found_data),
        .i_position    (position),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_found_count (found_count),
        .o_full_count  (full_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int pause_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [KEY_W-1:0] probe_key();
        int               r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (file_keys.size() == 0)
            return $urandom;
        k = file_keys[$urandom_range(0, file_keys.size() - 1)];
        if (r < 60)
            return k;
        if (r < 72)
            return k + 1;
        if (r < 82)
            return k - 1;
        if (r < 90)
            return $urandom;
        if (r < 93)
            return 32'h8000_0000;
        if (r < 96)
            return 32'h7FFF_FFFF;
        return file_keys[0] - 1;
    endfunction

    // returns at the edge that accepts the transaction, valid still high
    task automatic issue(t_cmd c, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
        int gap;
        gap = pause_cycles();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        key      <= k;
        payload  <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        case (c)
            CMD_APPEND: begin
                n_append++;
                if (file_keys.size() < CAPACITY)
                    file_keys.push_back(k);
            end
            CMD_SEARCH: n_search++;
            CMD_CLEAR: begin
                n_clear++;
                file_keys.delete();
            end
            default: ;
        endcase
    endtask

    // clear, load n records in non-decreasing key order, then search them, with a
    // random command now and then; probe_every > 0 also mixes searches into the load
    task automatic sorted_session(int n, int probe_every);
        longint step_max;
        longint span;
        longint k;
        int     m;
        issue(CMD_CLEAR, $urandom, $urandom);
        case ($urandom_range(0, 3))
            0: step_max = 1;
            1: step_max = 16;
            2: step_max = 65536;
            default: step_max = 64'd4294967295 / (2 * n);
        endcase
        span = 64'd4294967295 - n * step_max;
        k    = longint'($urandom_range(0, 32'(span))) - 64'sd2147483648;
        for (int i = 0; i < n; i++) begin
            issue(CMD_APPEND, k[31:0], $urandom);
            k += $urandom_range(0, 32'(step_max));
            if (probe_every > 0 && $urandom_range(1, probe_every) == 1)
                issue(CMD_SEARCH, probe_key(), $urandom);
        end
        m = $urandom_range(n / 2 + 2, n + 8);
        if (m > 60)
            m = 60;
        for (int i = 0; i < m; i++) begin
            if ($urandom_range(0, 99) < 8)
                issue(t_cmd'($urandom_range(0, 3)), $urandom, $urandom);
            else
                issue(CMD_SEARCH, probe_key(), $urandom);
        end
    endtask

    task automatic noise_session();
        int n;
        int r;
        n = $urandom_range(5, 30);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                issue(CMD_APPEND, $urandom, $urandom);
            else if (r < 80)
                issue(CMD_SEARCH, ($urandom_range(0, 1) == 1) ? probe_key() : $urandom, $urandom);
            else if (r < 88)
                issue(CMD_CLEAR, $urandom, $urandom);
            else
                issue(CMD_UNUSED, $urandom, $urandom);
        end
    endtask

    initial begin
        int hold;
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            hold = pause_cycles();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d responses outstanding", LIMIT, pending);
        $display("** indexed_page_key_search: FAILED **");
        $finish;
    end

    initial begin
        int random_start;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty store right after reset
        issue(CMD_SEARCH, 32'd0, 32'hFFFF_FFFF);
        issue(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(CMD_SEARCH, 32'h8000_0000, 32'd0);
        // one full page plus a short second page, duplicates in the first
        issue(CMD_APPEND, 32'h8000_0000, 32'hFFFF_FFFF);
        issue(CMD_APPEND, -32'sd100, 32'h0000_0000);
        issue(CMD_APPEND, -32'sd1, 32'h8000_0000);
        issue(CMD_APPEND, 32'sd0, 32'h7FFF_FFFF);
        issue(CMD_APPEND, 32'sd5, $urandom);
        issue(CMD_APPEND, 32'sd5, $urandom);
        issue(CMD_APPEND, 32'sd5, $urandom);
        issue(CMD_APPEND, 32'sd9, $urandom);
        issue(CMD_APPEND, 32'sd1000, $urandom);
        issue(CMD_APPEND, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
        issue(CMD_SEARCH, 32'h8000_0000, $urandom);
        issue(CMD_SEARCH, 32'h7FFF_FFFF, $urandom);
        issue(CMD_SEARCH, 32'sd5, $urandom);
        issue(CMD_SEARCH, 32'sd6, $urandom);
        // lands in page 0 and misses there, page 1 is never looked at
        issue(CMD_SEARCH, 32'sd999, $urandom);
        issue(CMD_SEARCH, 32'sd1000, $urandom);
        issue(CMD_CLEAR, $urandom, $urandom);
        issue(CMD_SEARCH, 32'sd5, $urandom);
        // key below the first page key
        issue(CMD_APPEND, 32'sd50, $urandom);
        issue(CMD_SEARCH, 32'sd49, $urandom);
        issue(CMD_SEARCH, 32'sd50, $urandom);

        random_start = sent;
        while (sent - random_start < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                noise_session();
            else if ($urandom_range(0, 9) == 0)
                sorted_session($urandom_range(40, 120), 4);
            else
                sorted_session($urandom_range(1, 40), 4);
        end

        // fill the store to capacity, then append; a random clear may empty it
        steady = 1'b0;
        sorted_session(CAPACITY, 16);
        repeat (3)
            issue(CMD_APPEND, $urandom, $urandom);
        issue(CMD_SEARCH, probe_key(), $urandom);
        issue(CMD_UNUSED, $urandom, $urandom);

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("covered %0d commands: %0d appends (%0d dropped when full),",
                 sent, n_append, full_count);
        $display("%0d searches (%0d found), %0d clears, idle gaps and output stalls",
                 n_search, found_count, n_clear);
        if (fail_count == 0 && pending == 0)
            $display("** indexed_page_key_search: PASSED **");
        else
            $display("** indexed_page_key_search: FAILED **");
        $finish;
    end

endmodule
